### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, off while reset is low
`define PTTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define PTTS_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAX_OUT    = 8;
    localparam int EMIT_W     = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int CNT_W      = 24;
    localparam int TPM_W      = 8;
    localparam int MUL_CNT_W  = $clog2(TPM_W);
    localparam int ID_W       = 8;
    localparam int OFS_W      = 16;
    localparam int PER_W      = 16;
    localparam int DISP_ID_W  = 3;

    localparam logic [TPM_W-1:0] TPM_RESET = 8'd1;

    typedef enum logic [1:0] {
        ACT_ENABLE  = 2'd0,
        ACT_DISABLE = 2'd1,
        ACT_TICK    = 2'd2,
        ACT_RUN     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'h0,
        MODE_IDLE = 2'h1,
        MODE_PEND = 2'h2
    } mode_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_RUN    = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NOTFOUND = 1'b1;

    localparam logic REG_TPM = 1'b0;

endpackage

### sv/ptts_alu.sv
// ----------------------------------------------------------------------------
// ptts_alu
// Shared 24-bit adder with zero detect on the first operand.
// ----------------------------------------------------------------------------
module ptts_alu
    import ptts_pkg::*;
(
    input  logic [CNT_W-1:0] op_a,
    input  logic [CNT_W-1:0] op_b,
    output logic [CNT_W-1:0] sum,
    output logic             a_zero
);

    assign sum    = op_a + op_b;
    assign a_zero = (op_a == '0);

endmodule

### sv/periodic_task_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_core
// Task slot table with tick countdowns, enable/disable and run dispatch.
// Enable: shift-add multiply of period by ticks_per_ms in the shared adder, then a
//   status reply; an unknown task_id goes straight to the reply. Disable: turns the
//   slot off, then a status reply. Tick: one slot per cycle through the shared adder,
//   no result. Run: dispatches each pending slot, waiting on the output, or only a
//   reply with none pending. No new item is accepted until the last one is done.
// Synchronous active-low reset disables all slots and sets ticks_per_ms to 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_task_tick_scheduler_core
    import ptts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // task_id[7:0], start_offset[23:8], period_ms[39:24]
    input  logic [1:0]  s_tuser,   // action[1:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // status[0], dispatched_id[3:1], dispatched_valid[4], 0[7:5]
    output logic        m_tuser,   // reply_kind[0]
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_TICK,
        S_RUN,
        S_REPLY
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    logic [SLOT_IDX_W-1:0] id_reg, id_next;
    logic [MUL_CNT_W-1:0]  mul_cnt_reg, mul_cnt_next;
    logic [CNT_W-1:0]      acc_reg, acc_next;
    logic [TPM_W-1:0]      tpm_sh_reg, tpm_sh_next;
    logic [OFS_W-1:0]      offset_reg, offset_next;
    logic [PER_W-1:0]      period_reg, period_next;
    logic                  rep_kind_reg, rep_kind_next;
    logic                  rep_status_reg, rep_status_next;
    logic [NUM_SLOTS-1:0]  pend_reg, pend_next;
    logic [EMIT_W-1:0]     emit_cnt_reg, emit_cnt_next;
    logic [TPM_W-1:0]      tpm_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  out_kind_reg, out_kind_next;
    logic                  out_status_reg, out_status_next;
    logic [DISP_ID_W-1:0]  out_id_reg, out_id_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_last_reg, out_last_next;

    mode_t                 mode_reg [NUM_SLOTS];
    logic [CNT_W-1:0]      cd_mem [NUM_SLOTS];
    logic [CNT_W-1:0]      rl_mem [NUM_SLOTS];

    logic                  mode_we;
    logic [SLOT_IDX_W-1:0] mode_waddr;
    mode_t                 mode_wdata;
    logic                  cd_we;
    logic [CNT_W-1:0]      cd_wdata;
    logic                  rl_we;
    logic [SLOT_IDX_W-1:0] slot_waddr;

    logic [CNT_W-1:0]      alu_a, alu_b, alu_sum;
    logic                  alu_zero;
    logic                  out_free;
    logic                  id_ok;
    logic                  run_last;
    logic [NUM_SLOTS-1:0]  pend_now;
    logic [NUM_SLOTS-1:0]  later_pend;
    mode_t                 cur_mode;
    logic                  cfg_wr;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TPM);
    assign prdata = (paddr[2] == REG_TPM) ? {24'd0, tpm_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpm_reg <= TPM_RESET;
        end else if (cfg_wr) begin
            tpm_reg <= pwdata[TPM_W-1:0];
        end
    end

    ptts_alu u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .sum    (alu_sum),
        .a_zero (alu_zero)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign cur_mode = mode_reg[idx_reg];
    assign id_ok    = (s_tdata[ID_W-1:0] < ID_W'(NUM_SLOTS));

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            pend_now[i]   = (mode_reg[i] == MODE_PEND);
            later_pend[i] = pend_reg[i] && (SLOT_IDX_W'(i) > idx_reg);
        end
    end

    assign run_last = !(|later_pend) || (emit_cnt_reg == EMIT_W'(MAX_OUT - 1));

    always_comb begin
        if (state_reg == S_MUL) begin
            alu_a = {acc_reg[CNT_W-2:0], 1'b0};
            alu_b = tpm_sh_reg[TPM_W-1] ? CNT_W'(period_reg) : '0;
        end else begin
            alu_a = cd_mem[idx_reg];
            alu_b = '1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        id_next         = id_reg;
        mul_cnt_next    = mul_cnt_reg;
        acc_next        = acc_reg;
        tpm_sh_next     = tpm_sh_reg;
        offset_next     = offset_reg;
        period_next     = period_reg;
        rep_kind_next   = rep_kind_reg;
        rep_status_next = rep_status_reg;
        pend_next       = pend_reg;
        emit_cnt_next   = emit_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        mode_we         = 1'b0;
        mode_waddr      = idx_reg;
        mode_wdata      = MODE_IDLE;
        cd_we           = 1'b0;
        cd_wdata        = alu_sum;
        rl_we           = 1'b0;
        slot_waddr      = idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    id_next       = s_tdata[SLOT_IDX_W-1:0];
                    offset_next   = s_tdata[ID_W +: OFS_W];
                    period_next   = s_tdata[ID_W+OFS_W +: PER_W];
                    idx_next      = '0;
                    acc_next      = '0;
                    mul_cnt_next  = '0;
                    tpm_sh_next   = tpm_reg;
                    emit_cnt_next = '0;
                    pend_next     = pend_now;
                    unique case (action_t'(s_tuser))
                        ACT_ENABLE: begin
                            rep_kind_next   = KIND_STATUS;
                            rep_status_next = id_ok ? STATUS_OK : STATUS_NOTFOUND;
                            state_next      = id_ok ? S_MUL : S_REPLY;
                        end
                        ACT_DISABLE: begin
                            mode_we         = id_ok;
                            mode_waddr      = s_tdata[SLOT_IDX_W-1:0];
                            mode_wdata      = MODE_OFF;
                            rep_kind_next   = KIND_STATUS;
                            rep_status_next = id_ok ? STATUS_OK : STATUS_NOTFOUND;
                            state_next      = S_REPLY;
                        end
                        ACT_TICK: begin
                            state_next = S_TICK;
                        end
                        ACT_RUN: begin
                            rep_kind_next   = KIND_RUN;
                            rep_status_next = STATUS_OK;
                            state_next      = (pend_now == '0) ? S_REPLY : S_RUN;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                acc_next     = alu_sum;
                tpm_sh_next  = {tpm_sh_reg[TPM_W-2:0], 1'b0};
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == MUL_CNT_W'(TPM_W - 1)) begin
                    slot_waddr = id_reg;
                    mode_waddr = id_reg;
                    cd_we      = 1'b1;
                    cd_wdata   = CNT_W'(offset_reg);
                    rl_we      = 1'b1;
                    mode_we    = 1'b1;
                    mode_wdata = MODE_IDLE;
                    state_next = S_REPLY;
                end
            end
            S_TICK: begin
                if (cur_mode != MODE_OFF) begin
                    cd_we = 1'b1;
                    if (alu_zero) begin
                        cd_wdata   = rl_mem[idx_reg];
                        mode_we    = 1'b1;
                        mode_wdata = MODE_PEND;
                    end
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_IDX_W'(NUM_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_RUN: begin
                if (pend_reg[idx_reg]) begin
                    if (out_free) begin
                        m_tvalid_next   = 1'b1;
                        out_kind_next   = KIND_RUN;
                        out_status_next = STATUS_OK;
                        out_id_next     = DISP_ID_W'(idx_reg);
                        out_valid_next  = 1'b1;
                        out_last_next   = run_last;
                        mode_we         = 1'b1;
                        mode_wdata      = MODE_IDLE;
                        emit_cnt_next   = emit_cnt_reg + 1'b1;
                        idx_next        = idx_reg + 1'b1;
                        if (run_last || idx_reg == SLOT_IDX_W'(NUM_SLOTS - 1)) begin
                            state_next = S_IDLE;
                        end
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == SLOT_IDX_W'(NUM_SLOTS - 1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_kind_next   = rep_kind_reg;
                    out_status_next = rep_status_reg;
                    out_id_next     = '0;
                    out_valid_next  = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg        <= idx_next;
        id_reg         <= id_next;
        mul_cnt_reg    <= mul_cnt_next;
        acc_reg        <= acc_next;
        tpm_sh_reg     <= tpm_sh_next;
        offset_reg     <= offset_next;
        period_reg     <= period_next;
        rep_kind_reg   <= rep_kind_next;
        rep_status_reg <= rep_status_next;
        pend_reg       <= pend_next;
        emit_cnt_reg   <= emit_cnt_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_valid_reg  <= out_valid_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                mode_reg[i] <= MODE_OFF;
            end
        end else if (mode_we) begin
            mode_reg[mode_waddr] <= mode_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cd_we) begin
            cd_mem[slot_waddr] <= cd_wdata;
        end
        if (rl_we) begin
            rl_mem[slot_waddr] <= alu_sum;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, out_valid_reg, out_id_reg, out_status_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `PTTS_ASSERT(a_tick_busy, aclk, aresetn,
        (s_tvalid && s_tready && s_tuser == ACT_TICK) |=> !s_tready,
        "tick item did not occupy sequencer")
    `PTTS_ASSERT(a_dispatch_kind, aclk, aresetn,
        (m_tvalid && out_valid_reg) |-> (out_kind_reg == KIND_RUN), "dispatch on status reply")
    `PTTS_ASSERT(a_notfound_last, aclk, aresetn,
        (m_tvalid && out_status_reg == STATUS_NOTFOUND) |->
            (out_kind_reg == KIND_STATUS && out_last_reg),
        "bad not-found reply")

endmodule
